// ===== hdl/ise_pkg.sv =====
`timescale 1ns / 1ps

package ise_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;

    typedef logic signed [DATA_W-1:0] value_t;

endpackage

// ===== hdl/ise_if.sv =====
`timescale 1ns / 1ps

interface ise_in_if import ise_pkg::*; ();

    logic   valid;
    logic   ready;
    value_t value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

interface ise_out_if import ise_pkg::*; ();

    logic   valid;
    logic   ready;
    value_t value_res;
    logic   last_res;
    logic   dropped;

    modport source (output valid, output value_res, output last_res, output dropped,
                    input ready);
    modport sink   (input valid, input value_res, input last_res, input dropped,
                    output ready);

endinterface

// ===== hdl/insertion_sort_engine.sv =====
`timescale 1ns / 1ps

// Insertion sort of one set of signed 32-bit words. Each input word is placed
// into a sorted single-port-write store by walking down from the top entry and
// moving every strictly larger entry up one place, one entry per cycle, so the
// block is not ready while the walk runs; a word into an empty or a full
// store needs no walk. Equal values keep arrival order. After the word marked
// last the store is read out in ascending order, the final one marked, and
// the store is emptied. Words arriving at a full store are discarded and
// every output word of that set then carries dropped. Input is taken again
// as soon as the final output word is loaded into the output register.
module insertion_sort_engine import ise_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    ise_in_if.sink          items,
    ise_out_if.source       results
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            ovf_reg, ovf_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [AW-1:0]   idx_reg, idx_next;
    value_t          val_reg, val_next;
    logic            last_reg, last_next;
    logic            out_valid_reg, out_valid_next;
    value_t          out_value_reg, out_value_next;
    logic            out_last_reg, out_last_next;
    logic            out_drop_reg, out_drop_next;

    logic            we;
    logic [AW-1:0]   waddr;
    value_t          wdata;
    logic [AW-1:0]   raddr;
    value_t          rdata;

    logic            full;
    logic            slot_free;
    logic            final_word;

    ise_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign full       = (fill_reg == CW'(DEPTH));
    assign slot_free  = !out_valid_reg || results.ready;
    assign final_word = ((CW'(idx_reg) + CW'(1)) == fill_reg);

    assign items.ready       = (state_reg == S_IDLE);
    assign results.valid     = out_valid_reg;
    assign results.value_res = out_value_reg;
    assign results.last_res  = out_last_reg;
    assign results.dropped   = out_drop_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = val_reg;
        raddr          = idx_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                raddr = fill_reg[AW-1:0] - AW'(1);
                if (items.valid)
                begin
                    val_next  = items.value;
                    last_next = items.last;
                    pos_next  = fill_reg[AW-1:0];
                    idx_next  = '0;
                    if (full)
                    begin
                        // drop
                        ovf_next   = 1'b1;
                        state_next = items.last ? S_EMIT_RD : S_IDLE;
                    end
                    else if (fill_reg == '0)
                    begin
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = items.value;
                        fill_next  = fill_reg + CW'(1);
                        state_next = items.last ? S_EMIT_RD : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                raddr = pos_reg - AW'(2);
                we    = 1'b1;
                waddr = pos_reg;
                if (pos_reg != '0 && $signed(rdata) > $signed(val_reg))
                begin
                    // move the larger entry up
                    wdata    = rdata;
                    pos_next = pos_reg - AW'(1);
                end
                else
                begin
                    wdata      = val_reg;
                    fill_next  = fill_reg + CW'(1);
                    idx_next   = '0;
                    state_next = last_reg ? S_EMIT_RD : S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rdata;
                    out_last_next  = final_word;
                    out_drop_next  = ovf_reg;
                    if (final_word)
                    begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_drop_reg  <= out_drop_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond store depth");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> CW'(pos_reg) < fill_reg + CW'(1) && !full)
        else $error("insert position outside filled range");

    a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT_LD && slot_free && final_word
        |=> fill_reg == '0 && !ovf_reg && results.valid && results.last_res)
        else $error("store not emptied after final word");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT_RD |-> fill_reg != '0 && CW'(idx_reg) < fill_reg)
        else $error("read-out index outside filled range");

endmodule

// ===== hdl/ise_store.sv =====
`timescale 1ns / 1ps

module ise_store import ise_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  value_t        wdata,
    input  logic [AW-1:0] raddr,
    output value_t        rdata
);

    value_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== verif/tb_insertion_sort_engine.sv =====
`timescale 1ns / 1ps

module tb_insertion_sort_engine;
    import ise_pkg::*;

    localparam int SORT_DEPTH = DEPTH_DEF;
    localparam int IDLE_LIMIT = 6000;
    localparam int TAIL_CYCLES = 3 * SORT_DEPTH + 16;
    localparam int RANDOM_WORDS = 500;
    localparam int HOLD_CYCLES = 500;

    localparam value_t VAL_MIN = 32'sh8000_0000;
    localparam value_t VAL_MAX = 32'sh7fff_ffff;

    typedef enum int {
        PICK_FULL,
        PICK_TIES,
        PICK_EXTREME
    } pick_mode_t;

    typedef struct {
        value_t value;
        logic   last_res;
        logic   dropped;
    } sorted_word_t;

    class sorted_set_checker;
        value_t       set_store[$];
        bit           set_overflow;
        sorted_word_t words_due[$];
        int           errors;

        function new();
            set_overflow = 0;
            errors = 0;
        endfunction

        function void note_word(value_t v, logic is_last);
            int pos;
            sorted_word_t w;
            if (set_store.size() >= SORT_DEPTH) begin
                set_overflow = 1;
            end
            else begin
                pos = set_store.size();
                while (pos > 0 && set_store[pos-1] > v) begin
                    pos--;
                end
                set_store.insert(pos, v);
            end
            if (is_last) begin
                foreach (set_store[k]) begin
                    w.value = set_store[k];
                    w.last_res = (k == set_store.size() - 1);
                    w.dropped = set_overflow;
                    words_due.push_back(w);
                end
                set_store.delete();
                set_overflow = 0;
            end
        endfunction

        function void check_word(value_t v, logic is_last, logic drop);
            sorted_word_t w;
            if (words_due.size() == 0) begin
                $display("%0t: unexpected word value %0d last_res %0b dropped %0b",
                         $time, v, is_last, drop);
                errors++;
                return;
            end
            w = words_due.pop_front();
            if (v !== w.value) begin
                $display("%0t: value_res expected %0d actual %0d", $time, w.value, v);
                errors++;
            end
            if (is_last !== w.last_res) begin
                $display("%0t: last_res expected %0b actual %0b", $time, w.last_res, is_last);
                errors++;
            end
            if (drop !== w.dropped) begin
                $display("%0t: dropped expected %0b actual %0b", $time, w.dropped, drop);
                errors++;
            end
        endfunction

        function int words_pending();
            return words_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ise_in_if  items_ch ();
    ise_out_if results_ch ();

    insertion_sort_engine #(
        .DEPTH (SORT_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    sorted_set_checker sorter_check = new();

    int burst_left = 0;
    int words_seen = 0;
    int idle_cycles = 0;

    initial begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && results_ch.valid && results_ch.ready) begin
            sorter_check.check_word(results_ch.value_res, results_ch.last_res,
                                    results_ch.dropped);
            words_seen++;
        end
    end

    always @(posedge clk) begin
        if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)) begin
            idle_cycles = 0;
        end
        else if (rst_n) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        int span;
        bit held;
        held = 0;
        results_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(posedge clk);
                if (!held && words_seen >= 40) begin
                    held = 1;
                    results_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0: results_ch.ready <= 1'b1;
                    1: results_ch.ready <= 1'($urandom_range(0, 1));
                    2: results_ch.ready <= ($urandom_range(0, 7) == 0);
                    default: results_ch.ready <= ~results_ch.ready;
                endcase
            end
        end
    end

    function automatic value_t pick_value(pick_mode_t mode);
        value_t v;
        case (mode)
            PICK_TIES: v = value_t'($urandom_range(0, 8)) - 4;
            PICK_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = 0;
                    3: v = -1;
                    default: v = value_t'($urandom);
                endcase
            end
            default: v = value_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_word(input value_t v, input logic is_last);
        if (burst_left == 0) begin
            items_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        items_ch.valid <= 1'b1;
        items_ch.value <= v;
        items_ch.last  <= is_last;
        do @(posedge clk); while (!items_ch.ready);
        sorter_check.note_word(v, is_last);
    endtask

    task automatic send_set(input int n, input pick_mode_t mode);
        for (int k = 0; k < n; k++) begin
            send_word(pick_value(mode), k == n - 1);
        end
    endtask

    initial begin
        int sent;
        int set_idx;
        int n;
        int big_sizes[4];
        pick_mode_t mode;

        big_sizes = '{SORT_DEPTH, SORT_DEPTH + 1, SORT_DEPTH + 6, SORT_DEPTH - 1};
        rst_n = 1'b0;
        items_ch.valid = 1'b0;
        items_ch.value = '0;
        items_ch.last = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(VAL_MIN, 1'b1);
        send_word(VAL_MAX, 1'b1);

        send_word(VAL_MAX, 1'b0);
        send_word(VAL_MIN, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b1);

        send_word(5, 1'b0);
        send_word(-3, 1'b0);
        send_word(5, 1'b0);
        send_word(5, 1'b0);
        send_word(-3, 1'b1);

        send_word(4, 1'b0);
        send_word(3, 1'b0);
        send_word(2, 1'b0);
        send_word(1, 1'b1);

        send_word(-2, 1'b0);
        send_word(-1, 1'b0);
        send_word(0, 1'b1);

        sent = 0;
        set_idx = 0;
        while (sent < RANDOM_WORDS) begin
            mode = pick_mode_t'($urandom_range(0, 2));
            if (set_idx % 12 == 3) begin
                n = big_sizes[(set_idx / 12) % 4];
            end
            else begin
                n = $urandom_range(1, 12);
            end
            send_set(n, mode);
            sent += n;
            set_idx++;
        end

        items_ch.valid <= 1'b0;
        while (sorter_check.words_pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sorter_check.errors == 0) begin
            $display("*** PASSED ***");
        end
        else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ise_pkg.sv
hdl/ise_if.sv
hdl/ise_store.sv
hdl/insertion_sort_engine.sv
verif/tb_insertion_sort_engine.sv
